### rtl/core/rss_pkg.sv
// rss_pkg: shared types and constants for the random subset selector
// holds the sequencer state type, register indexes and field widths
// depends on nothing
`default_nettype none

package rss_pkg;

  localparam int POP_MAX_DEF     = 1024;
  localparam int RANDOM_BITS_DEF = 32;

  localparam int CFG_W      = 11;
  localparam int CFG_IDX_W  = 1;
  localparam int WORD_W     = 32;
  localparam int CHOSEN_W   = 10;

  localparam logic [CFG_IDX_W-1:0] CFG_POPULATION_SIZE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SELECT_COUNT    = 1'b1;

  localparam logic KIND_RESTART = 1'b0;
  localparam logic KIND_DRAW    = 1'b1;

  localparam logic [CFG_W-1:0] POP_RESET = 11'd1024;
  localparam logic [CFG_W-1:0] SEL_RESET = 11'd0;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_SWAP_J,
    ST_SWAP_I
  } rss_state_t;

  // handshake between the sequencer and the remainder unit
  typedef struct packed {
    logic busy;
    logic done;
  } rss_div_stat_t;

endpackage

`default_nettype wire

### rtl/core/rss_mod_unit.sv
// rss_mod_unit: bit-serial restoring remainder, one dividend bit per cycle
// computes dividend mod divisor
// depends on rss_pkg
`default_nettype none

module rss_mod_unit
  import rss_pkg::*;
#(
  parameter int RANDOM_BITS = RANDOM_BITS_DEF,
  parameter int SPAN_W      = 11
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   start,
  input  wire logic [RANDOM_BITS-1:0] dividend,
  input  wire logic [SPAN_W-1:0]      divisor,
  output rss_div_stat_t               stat,
  output logic      [SPAN_W-1:0]      remainder
);

  localparam int CNT_W = $clog2(RANDOM_BITS);

  logic                   busy_r;
  logic                   done_r;
  logic [CNT_W-1:0]       cnt_r;
  logic [RANDOM_BITS-1:0] dvd_r;
  logic [SPAN_W-1:0]      div_r;
  logic [SPAN_W-1:0]      rem_r;
  logic [SPAN_W:0]        trial;
  logic [SPAN_W-1:0]      rem_nxt;

  // shift in the next dividend bit, subtract when it fits
  always_comb begin
    trial = {rem_r, dvd_r[RANDOM_BITS-1]};
    if (trial >= {1'b0, div_r}) begin
      rem_nxt = SPAN_W'(trial - {1'b0, div_r});
    end else begin
      rem_nxt = SPAN_W'(trial);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(RANDOM_BITS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      div_r <= divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[RANDOM_BITS-2:0], 1'b0};
      rem_r <= rem_nxt;
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign remainder = rem_r;

endmodule

`default_nettype wire

### rtl/core/random_subset_selector.sv
// random_subset_selector: partial shuffle draw of distinct indices, one per draw beat
// until select_count draws are done; the serial remainder unit picks a slot, followed by
// a registered table read and a swap in ST_SWAP_J then ST_SWAP_I, which loads the result
// a new beat is taken only in ST_IDLE, after the last draw's swap; exhausted draws give no result
// reset and restart beats sweep the index table to identity
`default_nettype none

module random_subset_selector
  import rss_pkg::*;
#(
  parameter int POP_MAX     = POP_MAX_DEF,
  parameter int RANDOM_BITS = RANDOM_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic                 in_kind,
  input  wire logic [WORD_W-1:0]    in_random_word,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic      [CHOSEN_W-1:0]  out_chosen_index,
  output logic                      out_last_of_selection,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data
);

  localparam int IDX_W = $clog2(POP_MAX);
  localparam int CNT_W = $clog2(POP_MAX + 1);

  rss_state_t state_r, state_nxt;

  logic [CFG_W-1:0] pop_r;
  logic [CFG_W-1:0] sel_r;
  logic [CNT_W-1:0] step_r;
  logic [CNT_W-1:0] k_r;
  logic [IDX_W-1:0] clr_r;
  logic [IDX_W-1:0] j_r;

  logic [IDX_W-1:0] mem [POP_MAX];
  logic [IDX_W-1:0] rd_i_r;
  logic [IDX_W-1:0] rd_j_r;

  logic             out_valid_r;
  logic [IDX_W-1:0] out_idx_r;
  logic             out_last_r;

  logic             in_accept;
  logic [CNT_W-1:0] n_sat;
  logic [CNT_W-1:0] k_sat;
  logic             can_draw;
  logic             div_start;
  logic             rd_en;
  logic [IDX_W-1:0] j_addr;
  logic             we;
  logic [IDX_W-1:0] waddr;
  logic [IDX_W-1:0] wdata;
  logic             commit;

  rss_div_stat_t    div_stat;
  logic [CNT_W-1:0] rem;

  rss_mod_unit #(
    .RANDOM_BITS (RANDOM_BITS),
    .SPAN_W      (CNT_W)
  ) u_mod (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (RANDOM_BITS'(in_random_word)),
    .divisor   (n_sat - step_r),
    .stat      (div_stat),
    .remainder (rem)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pop_r <= POP_RESET;
      sel_r <= SEL_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_POPULATION_SIZE: pop_r <= cfg_data;
        CFG_SELECT_COUNT:    sel_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // saturate n to the table depth and k to n
  always_comb begin
    if (32'(pop_r) > 32'(POP_MAX)) begin
      n_sat = CNT_W'(POP_MAX);
    end else begin
      n_sat = CNT_W'(pop_r);
    end
    if (32'(sel_r) > 32'(n_sat)) begin
      k_sat = n_sat;
    end else begin
      k_sat = CNT_W'(sel_r);
    end
  end

  assign can_draw  = step_r < k_sat;
  assign in_ready  = (state_r == ST_IDLE);
  assign in_accept = in_valid && in_ready;
  assign commit    = !out_valid_r || out_ready;
  assign j_addr    = IDX_W'(step_r + rem);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    div_start = 1'b0;
    rd_en     = 1'b0;
    we        = 1'b0;
    waddr     = clr_r;
    wdata     = clr_r;
    unique case (state_r)
      ST_CLEAR: begin
        we = 1'b1;
        if (clr_r == IDX_W'(POP_MAX - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_accept) begin
          if (in_kind == KIND_RESTART) begin
            state_nxt = ST_CLEAR;
          end else if (can_draw) begin
            div_start = 1'b1;
            state_nxt = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        if (div_stat.done) begin
          rd_en     = 1'b1;
          state_nxt = ST_SWAP_J;
        end
      end
      ST_SWAP_J: begin
        we        = 1'b1;
        waddr     = j_r;
        wdata     = rd_i_r;
        state_nxt = ST_SWAP_I;
      end
      ST_SWAP_I: begin
        waddr = IDX_W'(step_r);
        wdata = rd_j_r;
        if (commit) begin
          we        = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  // index table, one write and two registered reads
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (rd_en) begin
      rd_i_r <= mem[IDX_W'(step_r)];
      rd_j_r <= mem[j_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r  <= '0;
      step_r <= '0;
    end else begin
      if (state_r == ST_CLEAR) begin
        clr_r <= clr_r + 1'b1;
      end else if (in_accept && in_kind == KIND_RESTART) begin
        clr_r  <= '0;
        step_r <= '0;
      end
      if (state_r == ST_SWAP_I && commit) begin
        step_r <= step_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && in_kind == KIND_DRAW) begin
      k_r <= k_sat;
    end
    if (state_r == ST_DIV && div_stat.done) begin
      j_r <= j_addr;
    end
  end

  // output register, freed by the out beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_SWAP_I && commit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_SWAP_I && commit) begin
      out_idx_r  <= rd_j_r;
      out_last_r <= (step_r + 1'b1) == k_r;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_chosen_index      = CHOSEN_W'(out_idx_r);
  assign out_last_of_selection = out_last_r;

  a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.done |-> state_r == ST_DIV)
    else $error("remainder finished outside the divide state");

  a_busy_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.busy |-> state_r == ST_DIV)
    else $error("remainder unit busy outside the divide state");

  a_slot_order: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SWAP_J |-> (CNT_W'(j_r) >= step_r) && (step_r < k_r))
    else $error("swap slot below the draw step");

  a_out_from_swap: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_SWAP_I))
    else $error("result appeared without a finished swap");

endmodule

`default_nettype wire
